// ===== sv/prq_pkg.sv =====
// shared types and codes for the priority run queue scheduler
package prq_pkg;

   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int QUANTUM_W = 10;
   localparam int ID_W = 5;
   localparam int PRIO_W = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int SCAN_GROUP = 16;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 10'd10;

   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SWITCH = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TICK = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_POLICY = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOTQ = 2'd2;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DISP     = 12'b0000_0000_0010,
      ST_SW_LVL   = 12'b0000_0000_0100,
      ST_PUT      = 12'b0000_0000_1000,
      ST_PUT_LINK = 12'b0000_0001_0000,
      ST_SW_DEQ0  = 12'b0000_0010_0000,
      ST_SW_DEQ1  = 12'b0000_0100_0000,
      ST_SW_DEQ2  = 12'b0000_1000_0000,
      ST_REM_LVL  = 12'b0001_0000_0000,
      ST_REM_FIX  = 12'b0010_0000_0000,
      ST_SCAN     = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== sv/priority_run_queue_scheduler.sv =====
// priority run queue scheduler top level
//
//   channel  ports                      payload
//   request  req_tvalid/tready          tuser: action; tdata: thread_id, priority_req,
//                                       current_runnable, round_robin
//   result   rsp_tvalid/tready          tdata: status, current_thread, switched,
//                                       top_level, reschedule
//   csr      csr_valid/ready            csr_data: quantum_ticks
//
// the shortest items are tick, set policy and rejected items, the longest a switch
// with requeue into a busy level, dequeue and rescan; the sequence of dependent
// reads on the level and link rams sets the length, and a rescan adds the scan state.
// reset is synchronous; no clearing pass, the rams are covered by valid bits.
// one item is in work at a time; a new item is taken while a result waits,
// and the sequencer holds in its last step until the result register is free.
module priority_run_queue_scheduler #(
   parameter int LEVELS = 256,
   parameter int THREADS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser: action[2:0]
   input  logic [2:0]  req_tuser,
   // tdata: thread_id[4:0], priority_req[12:5], current_runnable[13], round_robin[14]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0], current_thread[6:2], switched[7], top_level[15:8], reschedule[16]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);

   localparam int LW = $clog2(LEVELS);
   localparam int TW = $clog2(THREADS);
   localparam int QW = prq_pkg::QUANTUM_W;

   prq_pkg::state_type state_ff, state_in;

   logic [prq_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [TW-1:0] tid_ff, tid_in;
   logic          idok_ff, idok_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          runok_ff, runok_in;
   logic          rrreq_ff, rrreq_in;
   logic [TW-1:0] pt_ff, pt_in;
   logic [LW-1:0] pl_ff, pl_in;
   logic          headmode_ff, headmode_in;
   logic [prq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic          switched_ff, switched_in;

   logic [LW-1:0] best_ff, best_in;
   logic [TW-1:0] running_ff, running_in;
   logic          resched_ff, resched_in;
   logic [QW-1:0] quantum_ff, quantum_in;
   logic [LEVELS-1:0]  occ_ff, occ_in;
   logic [THREADS-1:0] queued_ff, queued_in;
   logic [THREADS-1:0] rrpol_ff, rrpol_in;
   logic [QW-1:0] ticks_ff [THREADS];
   logic [QW-1:0] ticks_in [THREADS];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   // a scan was started, by a removal or by the dequeue emptying the best level
   logic          scan_pending_ff, scan_pending_in;

   // ram ports
   logic          lv_we, lv_re;
   logic [LW-1:0] lv_waddr, lv_raddr;
   logic [2*TW-1:0] lv_wdata, lv_rdata;
   logic [TW-1:0] lv_head, lv_tail;
   logic          nx_we, nx_re;
   logic [TW-1:0] nx_waddr, nx_raddr, nx_wdata, nx_rdata;
   logic          pv_we, pv_re;
   logic [TW-1:0] pv_waddr, pv_raddr, pv_wdata, pv_rdata;
   logic          tl_we, tl_re;
   logic [TW-1:0] tl_waddr, tl_raddr;
   logic [LW-1:0] tl_wdata, tl_rdata;

   logic [LW-1:0] scan_best;
   logic [QW-1:0] qv;
   logic [QW-1:0] cur_ticks;
   logic [7:0]    prio_in;

   assign lv_head = lv_rdata[2*TW-1:TW];
   assign lv_tail = lv_rdata[TW-1:0];
   assign qv = (quantum_ff == '0) ? QW'(1) : quantum_ff;
   assign cur_ticks = ticks_ff[running_ff];
   assign prio_in = req_tdata[12:5];

   prq_ram #(.WIDTH(2 * TW), .DEPTH(LEVELS)) u_level_ram (
      .clock(clock), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
      .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata)
   );

   prq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
      .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
   );

   prq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_prev_ram (
      .clock(clock), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
      .re(pv_re), .raddr(pv_raddr), .rdata(pv_rdata)
   );

   prq_ram #(.WIDTH(LW), .DEPTH(THREADS)) u_tlevel_ram (
      .clock(clock), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
      .re(tl_re), .raddr(tl_raddr), .rdata(tl_rdata)
   );

   prq_scan #(.LEVELS(LEVELS)) u_scan (
      .clock(clock), .occ(occ_ff), .best(scan_best)
   );

   assign req_tready = (state_ff == prq_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      tid_in = tid_ff;
      idok_in = idok_ff;
      lvl_in = lvl_ff;
      runok_in = runok_ff;
      rrreq_in = rrreq_ff;
      pt_in = pt_ff;
      pl_in = pl_ff;
      headmode_in = headmode_ff;
      status_in = status_ff;
      switched_in = switched_ff;
      best_in = best_ff;
      running_in = running_ff;
      resched_in = resched_ff;
      quantum_in = (csr_valid) ? csr_data : quantum_ff;
      occ_in = occ_ff;
      queued_in = queued_ff;
      rrpol_in = rrpol_ff;
      ticks_in = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      lv_we = 1'b0; lv_waddr = pl_ff; lv_wdata = '0; lv_re = 1'b0; lv_raddr = pl_ff;
      nx_we = 1'b0; nx_waddr = pt_ff; nx_wdata = '0; nx_re = 1'b0; nx_raddr = tid_ff;
      pv_we = 1'b0; pv_waddr = pt_ff; pv_wdata = '0; pv_re = 1'b0; pv_raddr = tid_ff;
      tl_we = 1'b0; tl_waddr = tid_ff; tl_wdata = lvl_ff; tl_re = 1'b0; tl_raddr = tid_ff;

      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tuser;
               idok_in = int'(req_tdata[4:0]) < THREADS;
               tid_in = TW'(req_tdata[4:0]);
               lvl_in = (int'(prio_in) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(prio_in);
               runok_in = req_tdata[13];
               rrreq_in = req_tdata[14];
               status_in = prq_pkg::STAT_OK;
               switched_in = 1'b0;
               state_in = prq_pkg::ST_DISP;
            end
         end
         prq_pkg::ST_DISP: begin
            state_in = prq_pkg::ST_DONE;
            case (act_ff)
               prq_pkg::ACT_ENQUEUE: begin
                  if (!idok_ff) begin
                     status_in = prq_pkg::STAT_NOTQ;
                  end else if (!queued_ff[tid_ff]) begin
                     tl_we = 1'b1;
                     pt_in = tid_ff;
                     pl_in = lvl_ff;
                     headmode_in = 1'b0;
                     state_in = prq_pkg::ST_PUT;
                  end
               end
               prq_pkg::ACT_REMOVE: begin
                  if (!idok_ff || !queued_ff[tid_ff]) begin
                     status_in = prq_pkg::STAT_NOTQ;
                  end else begin
                     tl_re = 1'b1;
                     nx_re = 1'b1;
                     pv_re = 1'b1;
                     state_in = prq_pkg::ST_REM_LVL;
                  end
               end
               prq_pkg::ACT_SWITCH: begin
                  if (runok_ff && !queued_ff[running_ff]) begin
                     tl_re = 1'b1;
                     tl_raddr = running_ff;
                     state_in = prq_pkg::ST_SW_LVL;
                  end else begin
                     state_in = prq_pkg::ST_SW_DEQ0;
                  end
               end
               prq_pkg::ACT_TICK: begin
                  if (rrpol_ff[running_ff]) begin
                     if (cur_ticks <= QW'(1)) begin
                        // quantum used up: reload and flag a reschedule
                        ticks_in[running_ff] = QW'({1'b0, cur_ticks} + {1'b0, qv} - (QW+1)'(1));
                        resched_in = 1'b1;
                     end else begin
                        ticks_in[running_ff] = cur_ticks - QW'(1);
                     end
                  end
               end
               prq_pkg::ACT_POLICY: begin
                  if (!idok_ff) begin
                     status_in = prq_pkg::STAT_NOTQ;
                  end else begin
                     rrpol_in[tid_ff] = rrreq_ff;
                     ticks_in[tid_ff] = qv;
                  end
               end
               default: begin
               end
            endcase
         end
         prq_pkg::ST_SW_LVL: begin
            pt_in = running_ff;
            pl_in = tl_rdata;
            // preempted by a better level: back to the head of its own level
            headmode_in = tl_rdata > best_ff;
            state_in = prq_pkg::ST_PUT;
         end
         prq_pkg::ST_PUT: begin
            if (occ_ff[pl_ff]) begin
               lv_re = 1'b1;
               state_in = prq_pkg::ST_PUT_LINK;
            end else begin
               lv_we = 1'b1;
               lv_wdata = {pt_ff, pt_ff};
               occ_in[pl_ff] = 1'b1;
               queued_in[pt_ff] = 1'b1;
               if (!headmode_ff && pl_ff < best_ff) begin
                  best_in = pl_ff;
                  resched_in = 1'b1;
               end
               state_in = (act_ff == prq_pkg::ACT_SWITCH) ? prq_pkg::ST_SW_DEQ0 :
                                                            prq_pkg::ST_DONE;
            end
         end
         prq_pkg::ST_PUT_LINK: begin
            lv_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (headmode_ff) begin
               lv_wdata = {pt_ff, lv_tail};
               pv_waddr = lv_head;
               pv_wdata = pt_ff;
               nx_waddr = pt_ff;
               nx_wdata = lv_head;
            end else begin
               lv_wdata = {lv_head, pt_ff};
               nx_waddr = lv_tail;
               nx_wdata = pt_ff;
               pv_waddr = pt_ff;
               pv_wdata = lv_tail;
               if (pl_ff < best_ff) begin
                  best_in = pl_ff;
                  resched_in = 1'b1;
               end
            end
            queued_in[pt_ff] = 1'b1;
            state_in = (act_ff == prq_pkg::ACT_SWITCH) ? prq_pkg::ST_SW_DEQ0 :
                                                         prq_pkg::ST_DONE;
         end
         prq_pkg::ST_SW_DEQ0: begin
            resched_in = 1'b0;
            if (!occ_ff[best_ff]) begin
               status_in = prq_pkg::STAT_EMPTY;
               state_in = prq_pkg::ST_DONE;
            end else begin
               lv_re = 1'b1;
               lv_raddr = best_ff;
               pl_in = best_ff;
               state_in = prq_pkg::ST_SW_DEQ1;
            end
         end
         prq_pkg::ST_SW_DEQ1: begin
            nx_re = 1'b1;
            nx_raddr = lv_head;
            state_in = prq_pkg::ST_SW_DEQ2;
         end
         prq_pkg::ST_SW_DEQ2: begin
            queued_in[lv_head] = 1'b0;
            running_in = lv_head;
            switched_in = lv_head != running_ff;
            if (lv_head == lv_tail) begin
               occ_in[pl_ff] = 1'b0;
               state_in = prq_pkg::ST_SCAN;
            end else begin
               lv_we = 1'b1;
               lv_wdata = {nx_rdata, lv_tail};
               state_in = prq_pkg::ST_DONE;
            end
         end
         prq_pkg::ST_REM_LVL: begin
            pl_in = tl_rdata;
            lv_re = 1'b1;
            lv_raddr = tl_rdata;
            state_in = prq_pkg::ST_REM_FIX;
         end
         prq_pkg::ST_REM_FIX: begin
            queued_in[tid_ff] = 1'b0;
            if (lv_head == tid_ff && lv_tail == tid_ff) begin
               occ_in[pl_ff] = 1'b0;
            end else if (lv_head == tid_ff) begin
               lv_we = 1'b1;
               lv_wdata = {nx_rdata, lv_tail};
            end else if (lv_tail == tid_ff) begin
               lv_we = 1'b1;
               lv_wdata = {lv_head, pv_rdata};
            end else begin
               nx_we = 1'b1;
               nx_waddr = pv_rdata;
               nx_wdata = nx_rdata;
               pv_we = 1'b1;
               pv_waddr = nx_rdata;
               pv_wdata = pv_rdata;
            end
            state_in = prq_pkg::ST_SCAN;
         end
         prq_pkg::ST_SCAN: begin
            // group stage of the scan registers this cycle
            state_in = prq_pkg::ST_DONE;
         end
         prq_pkg::ST_DONE: begin
            if (act_ff == prq_pkg::ACT_REMOVE && status_ff == prq_pkg::STAT_OK ||
                act_ff == prq_pkg::ACT_SWITCH && scan_pending_ff) begin
               best_in = scan_best;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {7'd0, resched_in, 8'(best_in), switched_ff,
                              5'(running_ff), status_ff};
               state_in = prq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      scan_pending_in = scan_pending_ff;
      if (state_ff == prq_pkg::ST_IDLE) begin
         scan_pending_in = 1'b0;
      end else if (state_ff == prq_pkg::ST_SCAN) begin
         scan_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::ST_IDLE;
         best_ff <= LW'(LEVELS - 1);
         running_ff <= '0;
         resched_ff <= 1'b1;
         quantum_ff <= prq_pkg::QUANTUM_RESET;
         occ_ff <= '0;
         queued_ff <= '0;
         rrpol_ff <= '1;
         for (int i = 0; i < THREADS; i++) begin
            ticks_ff[i] <= prq_pkg::QUANTUM_RESET;
         end
         rsp_valid_ff <= 1'b0;
         scan_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         best_ff <= best_in;
         running_ff <= running_in;
         resched_ff <= resched_in;
         quantum_ff <= quantum_in;
         occ_ff <= occ_in;
         queued_ff <= queued_in;
         rrpol_ff <= rrpol_in;
         ticks_ff <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_pending_ff <= scan_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      tid_ff <= tid_in;
      idok_ff <= idok_in;
      lvl_ff <= lvl_in;
      runok_ff <= runok_in;
      rrreq_ff <= rrreq_in;
      pt_ff <= pt_in;
      pl_ff <= pl_in;
      headmode_ff <= headmode_in;
      status_ff <= status_in;
      switched_ff <= switched_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sv/prq_ram.sv =====
// generic single write port ram with registered read
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/prq_scan.sv =====
// two-stage search for the best occupied level
module prq_scan #(
   parameter int LEVELS = 256
) (
   input  logic                      clock,
   input  logic [LEVELS-1:0]         occ,
   output logic [$clog2(LEVELS)-1:0] best
);

   localparam int LW = $clog2(LEVELS);
   localparam int GROUP = prq_pkg::SCAN_GROUP;
   localparam int NG = (LEVELS + GROUP - 1) / GROUP;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;

   logic [NG*GROUP-1:0] occ_pad;
   logic [GW-1:0]       grp_ff, grp_in;
   logic                any_ff, any_in;
   logic [GROUP-1:0]    bits;
   logic [$clog2(GROUP)-1:0] pos;

   // idle level is never searched
   always_comb begin
      occ_pad = '0;
      occ_pad[LEVELS-2:0] = occ[LEVELS-2:0];
   end

   always_comb begin
      grp_in = '0;
      any_in = 1'b0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (|occ_pad[g*GROUP +: GROUP]) begin
            grp_in = GW'(g);
            any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      any_ff <= any_in;
   end

   always_comb begin
      bits = occ_pad[int'(grp_ff)*GROUP +: GROUP];
      pos = '0;
      for (int b = GROUP - 1; b >= 0; b--) begin
         if (bits[b]) begin
            pos = ($clog2(GROUP))'(b);
         end
      end
      best = any_ff ? LW'(int'(grp_ff) * GROUP + int'(pos)) : LW'(LEVELS - 1);
   end

endmodule

// ===== sv/prq_chk.sv =====
// port-level checks for the priority run queue scheduler
module prq_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // one transaction in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == prq_pkg::STAT_OK ||
                     rsp_tdata[1:0] == prq_pkg::STAT_EMPTY ||
                     rsp_tdata[1:0] == prq_pkg::STAT_NOTQ)
      else $error("bad status code");

   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[1:0] == prq_pkg::STAT_OK)
      else $error("switched with error status");

endmodule

bind priority_run_queue_scheduler prq_chk u_prq_chk (.*);

// ===== tb/sv/prq_checker.sv =====
// checker for the priority run queue scheduler: watches request, result and csr channels
module prq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [9:0]  csr_data,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLEVELS = 256;
   localparam int NTHREADS = 32;

   typedef struct packed {
      logic       reschedule;
      logic [7:0] top_level;
      logic       switched;
      logic [4:0] current_thread;
      logic [1:0] status;
   } sched_result_type;

   logic [9:0] quantum;
   logic [4:0] lvl_head [NLEVELS];
   logic [4:0] lvl_tail [NLEVELS];
   logic       lvl_busy [NLEVELS];
   logic [4:0] nxt [NTHREADS];
   logic [4:0] prv [NTHREADS];
   logic [7:0] thr_lvl [NTHREADS];
   logic       thr_queued [NTHREADS];
   logic       thr_rr [NTHREADS];
   logic [9:0] thr_left [NTHREADS];
   logic [7:0] best;
   logic [4:0] running;
   logic       resched;

   sched_result_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic logic [9:0] quantum_eff();
      return (quantum == 0) ? 10'd1 : quantum;
   endfunction

   function automatic logic [7:0] find_best();
      for (int l = 0; l < NLEVELS - 1; l++)
         if (lvl_busy[l]) return l[7:0];
      return 8'(NLEVELS - 1);
   endfunction

   task automatic link_tail(input logic [4:0] t);
      logic [7:0] l;
      l = thr_lvl[t];
      if (lvl_busy[l]) begin
         nxt[lvl_tail[l]] = t;
         prv[t] = lvl_tail[l];
      end else begin
         lvl_head[l] = t;
         lvl_busy[l] = 1'b1;
      end
      lvl_tail[l] = t;
      thr_queued[t] = 1'b1;
   endtask

   task automatic link_head(input logic [4:0] t);
      logic [7:0] l;
      l = thr_lvl[t];
      if (lvl_busy[l]) begin
         prv[lvl_head[l]] = t;
         nxt[t] = lvl_head[l];
      end else begin
         lvl_tail[l] = t;
         lvl_busy[l] = 1'b1;
      end
      lvl_head[l] = t;
      thr_queued[t] = 1'b1;
   endtask

   task automatic unlink(input logic [4:0] t);
      logic [7:0] l;
      logic       hd, tl;
      l = thr_lvl[t];
      hd = (lvl_head[l] == t);
      tl = (lvl_tail[l] == t);
      if (hd && tl) lvl_busy[l] = 1'b0;
      else if (hd) lvl_head[l] = nxt[t];
      else if (tl) lvl_tail[l] = prv[t];
      else begin
         nxt[prv[t]] = nxt[t];
         prv[nxt[t]] = prv[t];
      end
      thr_queued[t] = 1'b0;
   endtask

   task automatic append_and_flag(input logic [4:0] t);
      link_tail(t);
      if (thr_lvl[t] < best) begin
         best = thr_lvl[t];
         resched = 1'b1;
      end
   endtask

   task automatic schedule_step(input logic [2:0] action, input logic [15:0] data);
      sched_result_type r;
      logic [4:0] tid, prev, nx;
      logic [9:0] left;
      tid = data[4:0];
      r = '0;
      case (action)
         prq_pkg::ACT_ENQUEUE: begin
            if (!thr_queued[tid]) begin
               thr_lvl[tid] = data[12:5];
               append_and_flag(tid);
            end
         end
         prq_pkg::ACT_REMOVE: begin
            if (!thr_queued[tid]) r.status = prq_pkg::STAT_NOTQ;
            else begin
               unlink(tid);
               best = find_best();
            end
         end
         prq_pkg::ACT_SWITCH: begin
            prev = running;
            if (data[13] && !thr_queued[prev]) begin
               if (thr_lvl[prev] > best) link_head(prev);
               else append_and_flag(prev);
            end
            resched = 1'b0;
            if (!lvl_busy[best]) r.status = prq_pkg::STAT_EMPTY;
            else begin
               nx = lvl_head[best];
               unlink(nx);
               if (!lvl_busy[best]) best = find_best();
               running = nx;
               r.switched = (nx != prev);
            end
         end
         prq_pkg::ACT_TICK: begin
            if (thr_rr[running]) begin
               if (thr_left[running] <= 1) begin
                  left = thr_left[running] - 10'd1 + quantum_eff();
                  resched = 1'b1;
               end else left = thr_left[running] - 10'd1;
               thr_left[running] = left;
            end
         end
         prq_pkg::ACT_POLICY: begin
            thr_rr[tid] = data[14];
            thr_left[tid] = quantum_eff();
         end
         default: ;
      endcase
      r.current_thread = running;
      r.top_level = best;
      r.reschedule = resched;
      expected_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      sched_result_type got, want;
      if (reset) begin
         quantum <= prq_pkg::QUANTUM_RESET;
         for (int l = 0; l < NLEVELS; l++) lvl_busy[l] = 1'b0;
         for (int t = 0; t < NTHREADS; t++) begin
            thr_lvl[t] = '0;
            thr_queued[t] = 1'b0;
            thr_rr[t] = 1'b1;
            thr_left[t] = 10'd10;
         end
         best = 8'(NLEVELS - 1);
         running = '0;
         resched = 1'b1;
      end else begin
         if (csr_valid && csr_ready) quantum <= csr_data;
         if (req_tvalid && req_tready) schedule_step(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[16:0];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.current_thread != want.current_thread)
                  report_mismatch("current_thread", got.current_thread, want.current_thread);
               if (got.switched != want.switched)
                  report_mismatch("switched", got.switched, want.switched);
               if (got.top_level != want.top_level)
                  report_mismatch("top_level", got.top_level, want.top_level);
               if (got.reschedule != want.reschedule)
                  report_mismatch("reschedule", got.reschedule, want.reschedule);
            end
         end
      end
   end

   initial error_count = 0;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top for the priority run queue scheduler: stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data = '0;
   int          error_count;
   int          pending_count;
   bit          sink_calm = 1'b0;
   int          sink_wait = 0;

   always #5 clock = ~clock;

   priority_run_queue_scheduler i_dut (.*);

   prq_checker i_checker (.*);

   task automatic send_item(input logic [2:0] action, input logic [4:0] tid,
                            input logic [7:0] prio, input logic runnable, input logic rr);
      int gap;
      gap = sink_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {1'b0, rr, runnable, prio, tid};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_quantum(input logic [9:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (12) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random item biased toward well-formed traffic over a few busy levels
   task automatic random_item();
      int pick;
      logic [7:0] prio;
      pick = $urandom_range(0, 99);
      prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      if (pick < 30)
         send_item(prq_pkg::ACT_ENQUEUE, 5'($urandom), prio, 1'($urandom), 1'($urandom));
      else if (pick < 45)
         send_item(prq_pkg::ACT_REMOVE, 5'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
      else if (pick < 70)
         send_item(prq_pkg::ACT_SWITCH, 5'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
      else if (pick < 90)
         send_item(prq_pkg::ACT_TICK, 5'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
      else if (pick < 97)
         send_item(prq_pkg::ACT_POLICY, 5'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
      else
         send_item(3'($urandom_range(5, 7)), 5'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom));
   endtask

   // result side waits a drawn number of cycles before each transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_tready <= 1'b0;
         sink_wait <= sink_calm ? 0 : $urandom_range(0, 8);
      end else if (rsp_tvalid && !rsp_tready) begin
         if (sink_wait == 0) rsp_tready <= 1'b1;
         else sink_wait <= sink_wait - 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // thread 0 is enqueued before any switch so its level is always written
      send_item(prq_pkg::ACT_ENQUEUE, 5'd0, 8'd255, 1'b1, 1'b0);
      send_item(prq_pkg::ACT_ENQUEUE, 5'd31, 8'd0, 1'b0, 1'b1);
      send_item(prq_pkg::ACT_ENQUEUE, 5'd31, 8'd7, 1'b0, 1'b1);
      send_item(prq_pkg::ACT_ENQUEUE, 5'd5, 8'd0, 1'b1, 1'b0);
      send_item(prq_pkg::ACT_ENQUEUE, 5'd6, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_ENQUEUE, 5'd7, 8'd254, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_REMOVE, 5'd5, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_REMOVE, 5'd5, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b1, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b1, 1'b0);
      send_item(prq_pkg::ACT_POLICY, 5'd31, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_TICK, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b1, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(prq_pkg::ACT_SWITCH, 5'd0, 8'd0, 1'b0, 1'b0);
      send_item(3'd7, 5'd3, 8'd3, 1'b1, 1'b1);
      send_item(prq_pkg::ACT_POLICY, 5'd3, 8'd0, 1'b0, 1'b1);
      for (int i = 0; i < 12; i++) send_item(prq_pkg::ACT_TICK, 5'd0, 8'd0, 1'b0, 1'b0);
      write_quantum(10'd1);
      for (int i = 0; i < 4; i++) send_item(prq_pkg::ACT_TICK, 5'd0, 8'd0, 1'b0, 1'b0);
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_quantum(10'd0);
            1: write_quantum(10'd1023);
            2: write_quantum(10'd3);
            3: write_quantum(10'($urandom_range(1, 1023)));
            4: write_quantum(10'd2);
            default: write_quantum(10'd10);
         endcase
         for (int i = 0; i < 300; i++) begin
            if (i % 100 == 0) sink_calm = ($urandom_range(0, 2) == 0);
            random_item();
         end
      end
      sink_calm = 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
